>>> rtl/knn_pkg.sv
// ---------------------------------------------------------------------------
// knn_pkg: shared types and codes for the vector search block
// Beat structs, command and status codes, register indexes.
// ---------------------------------------------------------------------------
package knn_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic REG_DIMENSION = 1'b0;
  localparam logic REG_METRIC    = 1'b1;

  localparam logic [6:0] DIMENSION_RESET = 7'd64;

  // Q16.16 one and two
  localparam logic [31:0] FIX_ONE = 32'h0001_0000;
  localparam logic [31:0] FIX_TWO = 32'h0002_0000;

  typedef struct packed {
    logic [1:0]          command;
    logic [31:0]         vector_id;
    logic signed [15:0]  element_value;
    logic [4:0]          top_k;
    logic                last;
  } knn_in_t;

  typedef struct packed {
    logic [31:0] match_id;
    logic [31:0] distance;
    logic [1:0]  status;
    logic        valid_match;
    logic        last_result;
  } knn_out_t;

endpackage

>>> rtl/knn_isqrt.sv
// ---------------------------------------------------------------------------
// knn_isqrt: iterative integer square root
// Digit-by-digit, one root bit per cycle; floor(sqrt(x)).
// ---------------------------------------------------------------------------
module knn_isqrt #(
  parameter int W = 56
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [W-1:0]         x,
  output logic                 done,
  output logic [W/2-1:0]       root
);

  localparam int RT_W = W / 2;
  localparam int CW   = $clog2(RT_W + 1);

  logic [W-1:0]    rad;
  logic [RT_W+1:0] rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [RT_W+1:0] rem_sh;
  logic [RT_W+1:0] trial;
  logic            take;

  assign rem_sh = {rem[RT_W-1:0], rad[W-1:W-2]};
  assign trial  = {root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rad  <= x;
      rem  <= '0;
      root <= '0;
      cnt  <= CW'(RT_W);
    end else if (busy) begin
      rad  <= {rad[W-3:0], 2'b00};
      rem  <= take ? rem_sh - trial : rem_sh;
      root <= {root[RT_W-2:0], take};
      cnt  <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/knn_dist.sv
// ---------------------------------------------------------------------------
// knn_dist: distance unit
// Streams element pairs through a product stage and accumulators, then
// finishes with a shared square root and, for cosine, a bit-serial divider.
// ---------------------------------------------------------------------------
module knn_dist
  import knn_pkg::*;
#(
  parameter int DIM_MAX = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               metric,
  input  logic               start,
  input  logic               el_valid,
  input  logic               el_last,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic               done,
  output logic [31:0]        distance
);

  localparam int ACC_W  = 32 + $clog2(DIM_MAX + 1);
  localparam int SQ_RAW = ACC_W + 16;
  localparam int SQ_W   = SQ_RAW + (SQ_RAW % 2);
  localparam int RT_W   = SQ_W / 2;
  localparam int DEN_W  = 2 * RT_W;
  localparam int DVD_W  = ACC_W + 16;
  localparam int DC_W   = $clog2(DVD_W + 1);
  localparam int EW     = RT_W > 32 ? RT_W : 32;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_SQA  = 6'b000010,
    F_SQB  = 6'b000100,
    F_MUL  = 6'b001000,
    F_DIV  = 6'b010000,
    F_OUT  = 6'b100000
  } fin_state_t;

  fin_state_t          fstate;
  logic                s1_valid;
  logic                s1_last;
  logic [31:0]         p_dd;
  logic signed [31:0]  p_xy;
  logic [31:0]         p_xx;
  logic [31:0]         p_yy;
  logic [ACC_W-1:0]    acc_s;
  logic signed [ACC_W:0] acc_dot;
  logic [ACC_W-1:0]    acc_na;
  logic [ACC_W-1:0]    acc_nb;
  logic                go;
  logic [RT_W-1:0]     ra;
  logic [RT_W-1:0]     rb;
  logic [DEN_W-1:0]    den;
  logic [DVD_W-1:0]    dvd;
  logic [DVD_W-1:0]    quo;
  logic [DEN_W:0]      rem;
  logic [DC_W-1:0]     dcnt;
  logic                neg;
  logic                sq_start;
  logic [SQ_W-1:0]     sq_x;
  logic                sq_done;
  logic [RT_W-1:0]     sq_root;
  logic signed [16:0]  diff;
  logic signed [33:0]  diff_sq;
  logic [ACC_W:0]      dot_abs;
  logic [DEN_W:0]      rem_sh;
  logic                rem_ge;
  logic [EW-1:0]       root_ext;
  logic                q_big;

  assign diff    = 17'(a) - 17'(b);
  assign diff_sq = diff * diff;
  assign dot_abs = acc_dot[ACC_W] ? (ACC_W+1)'(-acc_dot) : (ACC_W+1)'(acc_dot);
  assign rem_sh  = {rem[DEN_W-1:0], dvd[DVD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, den};
  assign root_ext = EW'(sq_root);
  assign q_big   = quo >= DVD_W'(FIX_ONE);

  // product stage, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      go       <= 1'b0;
    end else begin
      s1_valid <= el_valid;
      s1_last  <= el_valid && el_last;
      go       <= s1_valid && s1_last;
    end
    p_dd <= diff_sq[31:0];
    p_xy <= a * b;
    p_xx <= 32'(a * a);
    p_yy <= 32'(b * b);
    if (start) begin
      acc_s   <= '0;
      acc_dot <= '0;
      acc_na  <= '0;
      acc_nb  <= '0;
    end else if (s1_valid) begin
      acc_s   <= acc_s + ACC_W'(p_dd);
      acc_dot <= acc_dot + {{(ACC_W + 1 - 32){p_xy[31]}}, p_xy};
      acc_na  <= acc_na + ACC_W'(p_xx);
      acc_nb  <= acc_nb + ACC_W'(p_yy);
    end
  end

  always_comb begin
    sq_start = 1'b0;
    sq_x     = '0;
    unique case (fstate)
      F_IDLE: begin
        if (go) begin
          if (!metric) begin
            sq_start = 1'b1;
            sq_x     = SQ_W'({acc_s, 16'h0000});
          end else if (acc_na != '0 && acc_nb != '0) begin
            sq_start = 1'b1;
            sq_x     = SQ_W'(acc_na);
          end
        end
      end
      F_SQA: begin
        if (sq_done && metric) begin
          sq_start = 1'b1;
          sq_x     = SQ_W'(acc_nb);
        end
      end
      default: begin
        sq_start = 1'b0;
      end
    endcase
  end

  knn_isqrt #(.W(SQ_W)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (fstate)
        F_IDLE: begin
          if (go) begin
            if (metric && (acc_na == '0 || acc_nb == '0)) begin
              distance <= FIX_ONE;
              fstate   <= F_OUT;
            end else begin
              fstate <= F_SQA;
            end
          end
        end
        F_SQA: begin
          if (sq_done) begin
            if (!metric) begin
              distance <= (root_ext > EW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(sq_root);
              fstate   <= F_OUT;
            end else begin
              ra     <= sq_root;
              fstate <= F_SQB;
            end
          end
        end
        F_SQB: begin
          if (sq_done) begin
            rb     <= sq_root;
            fstate <= F_MUL;
          end
        end
        F_MUL: begin
          den    <= ra * rb;
          dvd    <= {dot_abs[ACC_W-1:0], 16'h0000};
          neg    <= acc_dot[ACC_W];
          rem    <= '0;
          quo    <= '0;
          dcnt   <= DC_W'(DVD_W);
          fstate <= F_DIV;
        end
        F_DIV: begin
          if (dcnt == '0) begin
            if (neg) begin
              distance <= q_big ? FIX_TWO : FIX_ONE + 32'(quo[15:0]);
            end else begin
              distance <= q_big ? 32'd0 : FIX_ONE - 32'(quo[15:0]);
            end
            fstate <= F_OUT;
          end else begin
            rem  <= rem_ge ? rem_sh - {1'b0, den} : rem_sh;
            quo  <= {quo[DVD_W-2:0], rem_ge};
            dvd  <= {dvd[DVD_W-2:0], 1'b0};
            dcnt <= dcnt - 1'b1;
          end
        end
        F_OUT: begin
          done   <= 1'b1;
          fstate <= F_IDLE;
        end
        default: begin
          fstate <= F_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/knn_best.sv
// ---------------------------------------------------------------------------
// knn_best: sorted k-nearest list
// One insertion per cycle; ties keep the earlier entry first.
// ---------------------------------------------------------------------------
module knn_best #(
  parameter int MAX_K = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          ins,
  input  logic [31:0]                   ins_dist,
  input  logic [31:0]                   ins_id,
  input  logic [$clog2(MAX_K+1)-1:0]    k,
  input  logic [(MAX_K>1 ? $clog2(MAX_K) : 1)-1:0] rd_idx,
  output logic [$clog2(MAX_K+1)-1:0]    count,
  output logic [31:0]                   rd_dist,
  output logic [31:0]                   rd_id
);

  localparam int KW = $clog2(MAX_K + 1);

  logic [31:0] dist_q [MAX_K];
  logic [31:0] id_q   [MAX_K];
  logic [KW-1:0] pos;

  always_comb begin
    pos = '0;
    for (int j = 0; j < MAX_K; j++) begin
      if (KW'(j) < count && dist_q[j] <= ins_dist) pos = pos + 1'b1;
    end
  end

  assign rd_dist = dist_q[rd_idx];
  assign rd_id   = id_q[rd_idx];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
    end else if (ins && pos < k) begin
      if (count < k) count <= count + 1'b1;
    end
    if (ins && pos < k) begin
      for (int j = 0; j < MAX_K; j++) begin
        if (KW'(j) == pos) begin
          dist_q[j] <= ins_dist;
          id_q[j]   <= ins_id;
        end
      end
      // entries behind the insertion point move down one place
      for (int j = 1; j < MAX_K; j++) begin
        if (KW'(j) > pos) begin
          dist_q[j] <= dist_q[j-1];
          id_q[j]   <= id_q[j-1];
        end
      end
    end
  end

endmodule

>>> rtl/knn_vector_search.sv
// ---------------------------------------------------------------------------
// knn_vector_search: brute-force k-nearest vector table
// Add, remove and query vectors of Q8.8 elements; results in Q16.16.
// ---------------------------------------------------------------------------
//  port group  | dir | handshake          | beat
//  in_*        | in  | in_valid/in_ready  | knn_in_t: one element or remove
//  out_*       | out | out_valid/out_ready| knn_out_t: one result
//  cfg_*       | in  | cfg_we             | dimension (0), metric (1)
//
// Element beats (not last) are taken one per cycle into the staging memory.
// A last add or a remove scans the id memory, one slot a cycle; an add then
// copies DIM_MAX words.
// A query runs per valid slot: dimension reads from the vector memory, then
// the square root unit (twice for cosine) and for cosine the divider. in_ready is
// low until the last result is loaded.
// Reset is synchronous; it clears slot valid bits, counts and the FSM.
// Results wait in an output register; a stalled out_ready only holds it.
// ---------------------------------------------------------------------------
module knn_vector_search
  import knn_pkg::*;
#(
  parameter int MAX_VECTORS = 64,
  parameter int DIM_MAX     = 64,
  parameter int MAX_K       = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  knn_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output knn_out_t  out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [6:0] cfg_wdata
);

  localparam int SLOT_W = MAX_VECTORS > 1 ? $clog2(MAX_VECTORS) : 1;
  localparam int IDX_W  = DIM_MAX > 1 ? $clog2(DIM_MAX) : 1;
  localparam int CNT_W  = $clog2(DIM_MAX + 2);
  localparam int VS_N   = MAX_VECTORS * DIM_MAX;
  localparam int VS_AW  = VS_N > 1 ? $clog2(VS_N) : 1;
  localparam int KW     = $clog2(MAX_K + 1);
  localparam int KI     = MAX_K > 1 ? $clog2(MAX_K) : 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SCAN  = 8'b00000010,
    S_COPY  = 8'b00000100,
    S_QSLOT = 8'b00001000,
    S_QRUN  = 8'b00010000,
    S_QWAIT = 8'b00100000,
    S_EMIT  = 8'b01000000,
    S_POST  = 8'b10000000
  } state_t;

  state_t state;

  // configuration
  logic [6:0] dimension;
  logic       metric;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIMENSION_RESET;
      metric    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIMENSION: dimension <= cfg_wdata;
        REG_METRIC:    metric    <= cfg_wdata[0];
        default:       metric    <= metric;
      endcase
    end
  end

  // memories
  logic signed [15:0] stg_mem [DIM_MAX];
  logic signed [15:0] vs_mem  [VS_N];
  logic [31:0]        sid_mem [MAX_VECTORS];

  logic               stg_we, stg_re;
  logic [IDX_W-1:0]   stg_waddr, stg_raddr;
  logic signed [15:0] stg_q;
  logic               vs_we, vs_re;
  logic [VS_AW-1:0]   vs_waddr, vs_raddr;
  logic signed [15:0] vs_wdata, vs_q;
  logic               sid_we, sid_re;
  logic [SLOT_W-1:0]  sid_waddr, sid_raddr;
  logic [31:0]        sid_q;
  logic [31:0]        cur_id;

  always_ff @(posedge clk) begin
    if (stg_we) stg_mem[stg_waddr] <= in_data.element_value;
    if (stg_re) stg_q <= stg_mem[stg_raddr];
  end

  always_ff @(posedge clk) begin
    if (vs_we) vs_mem[vs_waddr] <= vs_wdata;
    if (vs_re) vs_q <= vs_mem[vs_raddr];
  end

  always_ff @(posedge clk) begin
    if (sid_we) sid_mem[sid_waddr] <= cur_id;
    if (sid_re) sid_q <= sid_mem[sid_raddr];
  end

  // control registers
  logic [MAX_VECTORS-1:0] slot_valid;
  logic [CNT_W-1:0]       count;
  logic [KW-1:0]          cur_k;
  logic [1:0]             post_status;
  logic [SLOT_W:0]        ptr;
  logic                   pend;
  logic [SLOT_W-1:0]      pend_slot;
  logic                   found, free_found;
  logic [SLOT_W-1:0]      found_slot, free_slot, target;
  logic                   is_add;
  logic [CNT_W-1:0]       cp;
  logic                   cpend;
  logic [IDX_W-1:0]       cp_d;
  logic [VS_AW-1:0]       tbase;
  logic [VS_AW-1:0]       vbase;
  logic [IDX_W-1:0]       qi;
  logic                   el_valid, el_last;
  logic [KW-1:0]          eidx;

  // datapath links
  logic            accept;
  logic [CNT_W-1:0] count_inc;
  logic            dim_ok;
  logic [KW-1:0]   k_clamp;
  logic            out_free;
  logic            out_load;
  knn_out_t        out_next;
  logic            qissue, qlast;
  logic            dist_start, dist_done;
  logic [31:0]     dist_val;
  logic            best_clear, best_ins;
  logic [KW-1:0]   best_count;
  logic [31:0]     best_dist, best_id;
  logic            scan_end, copy_end;

  assign in_ready  = state == S_IDLE;
  assign accept    = in_valid && in_ready;
  assign count_inc = (32'(count) <= DIM_MAX) ? count + 1'b1 : count;
  assign dim_ok    = dimension != 7'd0 && 32'(dimension) <= DIM_MAX
                     && 32'(count_inc) == 32'(dimension);
  assign k_clamp   = (32'(in_data.top_k) > MAX_K) ? KW'(MAX_K) : KW'(in_data.top_k);
  assign out_free  = !out_valid || out_ready;
  assign scan_end  = ptr == (SLOT_W+1)'(MAX_VECTORS) && !pend;
  assign copy_end  = cp == CNT_W'(DIM_MAX) && !cpend;
  assign qissue    = state == S_QRUN;
  assign qlast     = 32'(qi) == 32'(dimension) - 32'd1;

  // memory port control
  always_comb begin
    stg_we    = 1'b0;
    stg_waddr = count[IDX_W-1:0];
    stg_re    = 1'b0;
    stg_raddr = qi;
    vs_we     = cpend;
    vs_waddr  = VS_AW'(tbase + VS_AW'(cp_d));
    vs_wdata  = (32'(cp_d) < 32'(dimension)) ? stg_q : 16'sd0;
    vs_re     = qissue;
    vs_raddr  = VS_AW'(vbase + VS_AW'(qi));
    sid_we    = state == S_COPY && copy_end;
    sid_waddr = target;
    sid_re    = 1'b0;
    sid_raddr = ptr[SLOT_W-1:0];
    if (accept && (in_data.command == CMD_ADD || in_data.command == CMD_QUERY)
        && 32'(count) < DIM_MAX) begin
      stg_we = 1'b1;
    end
    unique case (state)
      S_SCAN: begin
        sid_re = ptr != (SLOT_W+1)'(MAX_VECTORS);
      end
      S_COPY: begin
        stg_re    = cp != CNT_W'(DIM_MAX);
        stg_raddr = cp[IDX_W-1:0];
      end
      S_QSLOT: begin
        sid_re = ptr != (SLOT_W+1)'(MAX_VECTORS) && slot_valid[ptr[SLOT_W-1:0]];
      end
      S_QRUN: begin
        stg_re = 1'b1;
      end
      default: begin
        stg_re = 1'b0;
      end
    endcase
  end

  assign dist_start = state == S_QSLOT && sid_re;
  assign best_clear = accept && in_data.last && in_data.command == CMD_QUERY;
  assign best_ins   = state == S_QWAIT && dist_done;

  knn_dist #(.DIM_MAX(DIM_MAX)) u_dist (
    .clk      (clk),
    .rst      (rst),
    .metric   (metric),
    .start    (dist_start),
    .el_valid (el_valid),
    .el_last  (el_last),
    .a        (vs_q),
    .b        (stg_q),
    .done     (dist_done),
    .distance (dist_val)
  );

  knn_best #(.MAX_K(MAX_K)) u_best (
    .clk      (clk),
    .rst      (rst),
    .clear    (best_clear),
    .ins      (best_ins),
    .ins_dist (dist_val),
    .ins_id   (sid_q),
    .k        (cur_k),
    .rd_idx   (eidx[KI-1:0]),
    .count    (best_count),
    .rd_dist  (best_dist),
    .rd_id    (best_id)
  );

  // result register
  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    out_next.last_result = 1'b1;
    out_next.status      = post_status;
    if (state == S_POST && out_free) begin
      out_load = 1'b1;
    end else if (state == S_EMIT && best_count != '0 && out_free) begin
      out_load             = 1'b1;
      out_next.status      = ST_OK;
      out_next.match_id    = best_id;
      out_next.distance    = best_dist;
      out_next.valid_match = 1'b1;
      out_next.last_result = eidx == best_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) out_data <= out_next;
  end

  // element pipe into the distance unit lines up with the read latency
  always_ff @(posedge clk) begin
    if (rst) begin
      el_valid <= 1'b0;
      el_last  <= 1'b0;
      cpend    <= 1'b0;
    end else begin
      el_valid <= qissue;
      el_last  <= qissue && qlast;
      cpend    <= state == S_COPY && cp != CNT_W'(DIM_MAX);
    end
    cp_d <= cp[IDX_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      count      <= '0;
      pend       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_id     <= in_data.vector_id;
            ptr        <= '0;
            pend       <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            unique case (in_data.command)
              CMD_REMOVE: begin
                count  <= '0;
                is_add <= 1'b0;
                state  <= S_SCAN;
              end
              CMD_ADD, CMD_QUERY: begin
                if (!in_data.last) begin
                  count <= count_inc;
                end else begin
                  count <= '0;
                  if (!dim_ok) begin
                    post_status <= ST_MISMATCH;
                    state       <= S_POST;
                  end else if (in_data.command == CMD_ADD) begin
                    is_add <= 1'b1;
                    state  <= S_SCAN;
                  end else begin
                    cur_k <= k_clamp;
                    vbase <= '0;
                    if (k_clamp == '0) begin
                      post_status <= ST_OK;
                      state       <= S_POST;
                    end else begin
                      state <= S_QSLOT;
                    end
                  end
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (ptr != (SLOT_W+1)'(MAX_VECTORS)) ptr <= ptr + 1'b1;
          pend      <= ptr != (SLOT_W+1)'(MAX_VECTORS);
          pend_slot <= ptr[SLOT_W-1:0];
          if (pend) begin
            if (slot_valid[pend_slot] && sid_q == cur_id && !found) begin
              found      <= 1'b1;
              found_slot <= pend_slot;
            end
            if (!slot_valid[pend_slot] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= pend_slot;
            end
          end
          if (scan_end) begin
            post_status <= ST_OK;
            if (!is_add) begin
              if (found) slot_valid[found_slot] <= 1'b0;
              state <= S_POST;
            end else if (found || free_found) begin
              target <= found ? found_slot : free_slot;
              tbase  <= VS_AW'(32'(found ? found_slot : free_slot) * DIM_MAX);
              cp     <= '0;
              state  <= S_COPY;
            end else begin
              post_status <= ST_FULL;
              state       <= S_POST;
            end
          end
        end
        S_COPY: begin
          if (cp != CNT_W'(DIM_MAX)) cp <= cp + 1'b1;
          if (copy_end) begin
            slot_valid[target] <= 1'b1;
            state              <= S_POST;
          end
        end
        S_QSLOT: begin
          if (ptr == (SLOT_W+1)'(MAX_VECTORS)) begin
            eidx  <= '0;
            state <= S_EMIT;
          end else if (!slot_valid[ptr[SLOT_W-1:0]]) begin
            ptr   <= ptr + 1'b1;
            vbase <= VS_AW'(vbase + VS_AW'(DIM_MAX));
          end else begin
            qi    <= '0;
            state <= S_QRUN;
          end
        end
        S_QRUN: begin
          qi <= qi + 1'b1;
          if (qlast) state <= S_QWAIT;
        end
        S_QWAIT: begin
          if (dist_done) begin
            ptr   <= ptr + 1'b1;
            vbase <= VS_AW'(vbase + VS_AW'(DIM_MAX));
            state <= S_QSLOT;
          end
        end
        S_EMIT: begin
          if (best_count == '0) begin
            post_status <= ST_OK;
            state       <= S_POST;
          end else if (out_load) begin
            eidx <= eidx + 1'b1;
            if (out_next.last_result) state <= S_IDLE;
          end
        end
        S_POST: begin
          if (out_load) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
